[src/modular_exponentiation_assert.svh]
// Assertion macros used by the modular exponentiation top level.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/modexp_pkg.sv]
// Types, constants and the microcode table of the modular exponentiation block.
package modexp_pkg;

    // Microcode address and the named program steps.
    typedef logic [2:0] upc_t;

    localparam upc_t UPC_IDLE   = 3'd0;
    localparam upc_t UPC_LDBASE = 3'd1;
    localparam upc_t UPC_LDONE  = 3'd2;
    localparam upc_t UPC_SQR    = 3'd3;
    localparam upc_t UPC_MUL    = 3'd4;
    localparam upc_t UPC_NEXT   = 3'd5;
    localparam upc_t UPC_EMIT   = 3'd6;

    // Dividend source of a multiply-reduce step.
    typedef enum logic [1:0] {
        SRC_BASE = 2'd0,
        SRC_ONE  = 2'd1,
        SRC_SQR  = 2'd2,
        SRC_MUL  = 2'd3
    } src_t;

    // Sequencing condition of a control word.
    typedef enum logic [2:0] {
        JMP_SEQ      = 3'd0,
        JMP_WAIT_IN  = 3'd1,
        JMP_BIT_CLR  = 3'd2,
        JMP_MORE     = 3'd3,
        JMP_WAIT_OUT = 3'd4
    } jmp_t;

    // One control word.
    typedef struct packed {
        logic reduce;
        src_t src;
        logic wr_m;
        logic shift;
        logic emit;
        jmp_t jmp;
        upc_t target;
    } uword_t;

    // Control going into the multiply-reduce unit.
    typedef struct packed {
        logic start;
        logic use_mul;
        logic sqr;
    } mm_ctrl_t;

    // Status coming back from the multiply-reduce unit.
    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

    localparam logic [15:0] RESET_MODULUS = 16'd187;

    // Microcode program: reduce the base, seed the accumulator, then per exponent
    // bit square, conditionally multiply, and step to the next bit.
    function automatic uword_t ucode_rom(upc_t addr);
        uword_t w;
        begin
            w = '0;
            unique case (addr)
                UPC_IDLE:
                begin
                    w.jmp = JMP_WAIT_IN;
                end
                UPC_LDBASE:
                begin
                    w.reduce = 1'b1;
                    w.src    = SRC_BASE;
                    w.wr_m   = 1'b1;
                    w.jmp    = JMP_SEQ;
                end
                UPC_LDONE:
                begin
                    w.reduce = 1'b1;
                    w.src    = SRC_ONE;
                    w.jmp    = JMP_SEQ;
                end
                UPC_SQR:
                begin
                    w.reduce = 1'b1;
                    w.src    = SRC_SQR;
                    w.jmp    = JMP_BIT_CLR;
                    w.target = UPC_NEXT;
                end
                UPC_MUL:
                begin
                    w.reduce = 1'b1;
                    w.src    = SRC_MUL;
                    w.jmp    = JMP_SEQ;
                end
                UPC_NEXT:
                begin
                    w.shift  = 1'b1;
                    w.jmp    = JMP_MORE;
                    w.target = UPC_SQR;
                end
                UPC_EMIT:
                begin
                    w.emit   = 1'b1;
                    w.jmp    = JMP_WAIT_OUT;
                    w.target = UPC_IDLE;
                end
                default:
                begin
                    w.jmp    = JMP_WAIT_OUT;
                    w.target = UPC_IDLE;
                end
            endcase
            return w;
        end
    endfunction

endpackage

[src/modexp_mulmod.sv]
// Multiply-and-reduce unit: one registered multiply, then restoring reduction two bits a cycle.
module modexp_mulmod
    import modexp_pkg::*;
#(
    parameter int MOD_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mm_ctrl_t             ctrl,
    input  logic [MOD_WIDTH-1:0] a,
    input  logic [MOD_WIDTH-1:0] b,
    input  logic [15:0]          raw,
    input  logic [MOD_WIDTH-1:0] n,
    output mm_stat_t             stat,
    output logic [MOD_WIDTH-1:0] result
);

    localparam int PW   = (2 * MOD_WIDTH > 16) ? 2 * MOD_WIDTH : 16;
    localparam int STEPS = PW / 2;
    localparam int CW   = $clog2(STEPS);
    localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [PW-1:0]          div_reg, div_next;
    logic [MOD_WIDTH-1:0]   rem_reg, rem_next;
    logic [MOD_WIDTH-1:0]   mul_b;
    logic [2*MOD_WIDTH-1:0] prod;
    logic [MOD_WIDTH:0]     r1, r1_red, r2, r2_red;

    // Operand selection and the single multiplier.
    assign mul_b = ctrl.sqr ? a : b;
    assign prod  = a * mul_b;

    // Two restoring reduction steps, feeding the dividend from its top bits.
    assign r1     = {rem_reg, div_reg[PW-1]};
    assign r1_red = (r1 >= {1'b0, n}) ? (r1 - {1'b0, n}) : r1;
    assign r2     = {r1_red[MOD_WIDTH-1:0], div_reg[PW-2]};
    assign r2_red = (r2 >= {1'b0, n}) ? (r2 - {1'b0, n}) : r2;

    // Load on start, step while busy, flag done after the last step.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            div_next  = ctrl.use_mul ? PW'(prod) : PW'(raw);
        end
        else if (busy_reg)
        begin
            rem_next = r2_red[MOD_WIDTH-1:0];
            div_next = {div_reg[PW-3:0], 2'b00};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = rem_reg;

endmodule

[src/modular_exponentiation.sv]
// Top level: microcoded left-to-right square-and-multiply modular exponentiation.
//
//  Channel  Direction  Signals                       Contents
//  s_*      in         s_tvalid s_tready s_tdata     base (15:0), exponent (31:16)
//  m_*      out        m_tvalid m_tready m_tdata     power result (15:0)
//  cfg_*    in         cfg_wen cfg_wdata             modulus
//
// Each multiply-reduce step, PW = max(2*MOD_WIDTH, 16), is one multiply, two-bit
// reduction steps over the PW-bit dividend and one write-back. A request runs two
// steps to reduce the base and seed the accumulator, then per exponent bit a square,
// a multiply and a shift; a cleared exponent bit saves one step. The shared multiply-reduce unit
// sets the rate. Reset loads the modulus with 187. A new request is taken while a
// result waits; the sequencer holds at its last step until the output register is free.
`include "modular_exponentiation_assert.svh"

module modular_exponentiation
    import modexp_pkg::*;
#(
    parameter int EXP_WIDTH = 16,
    parameter int MOD_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // base_value [15:0], exponent_value [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // power_result [15:0]
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata
);

    localparam int BW = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;
    localparam logic [BW-1:0] BITS_INIT = BW'(EXP_WIDTH - 1);
    localparam logic [MOD_WIDTH+15:0] RST_EXT = {{MOD_WIDTH{1'b0}}, RESET_MODULUS};

    upc_t                 upc_reg, upc_next;
    logic [EXP_WIDTH-1:0] exp_reg, exp_next;
    logic [BW-1:0]        bits_left_reg, bits_left_next;
    logic [15:0]          base_reg, base_next;
    logic [MOD_WIDTH-1:0] acc_reg, acc_next;
    logic [MOD_WIDTH-1:0] m_reg, m_next;
    logic [MOD_WIDTH-1:0] mod_reg, mod_next;
    logic                 out_valid_reg, out_valid_next;
    logic [15:0]          power_reg, power_next;

    uword_t               uw;
    mm_ctrl_t             mm_ctrl;
    mm_stat_t             mm_stat;
    logic [MOD_WIDTH-1:0] mm_result;
    logic                 in_acc;
    logic                 out_free;
    logic                 go;
    logic [EXP_WIDTH+15:0] exp_ext;
    logic [MOD_WIDTH+15:0] cfg_ext;
    logic [MOD_WIDTH+15:0] res_ext;

    // Current control word.
    assign uw = ucode_rom(upc_reg);

    // Handshakes.
    assign s_tready = (upc_reg == UPC_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = power_reg;

    // Width adaption of exponent, configuration data and result.
    assign exp_ext = {{EXP_WIDTH{1'b0}}, s_tdata[31:16]};
    assign cfg_ext = {{MOD_WIDTH{1'b0}}, cfg_wdata};
    assign res_ext = {16'd0, acc_reg};

    // Multiply-reduce unit requests.
    assign mm_ctrl.start   = uw.reduce && !mm_stat.busy && !mm_stat.done;
    assign mm_ctrl.use_mul = (uw.src == SRC_SQR) || (uw.src == SRC_MUL);
    assign mm_ctrl.sqr     = (uw.src == SRC_SQR);

    modexp_mulmod #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mm_ctrl),
        .a      (acc_reg),
        .b      (m_reg),
        .raw    ((uw.src == SRC_BASE) ? base_reg : 16'd1),
        .n      (mod_reg),
        .stat   (mm_stat),
        .result (mm_result)
    );

    // A reducing step completes when the unit reports done.
    assign go = uw.reduce ? mm_stat.done : 1'b1;

    // Sequencer and datapath next state.
    always_comb
    begin
        upc_next       = upc_reg;
        exp_next       = exp_reg;
        bits_left_next = bits_left_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        m_next         = m_reg;
        mod_next       = mod_reg;
        out_valid_next = out_valid_reg && !m_tready;
        power_next     = power_reg;

        // Configuration write.
        if (cfg_wen)
        begin
            mod_next = cfg_ext[MOD_WIDTH-1:0];
        end

        // Capture a request.
        if (in_acc)
        begin
            base_next      = s_tdata[15:0];
            exp_next       = exp_ext[EXP_WIDTH-1:0];
            bits_left_next = BITS_INIT;
        end

        // Write back a reduced value.
        if (uw.reduce && mm_stat.done)
        begin
            if (uw.wr_m)
            begin
                m_next = mm_result;
            end
            else
            begin
                acc_next = mm_result;
            end
        end

        // Move to the next exponent bit.
        if (uw.shift)
        begin
            exp_next = exp_reg << 1;
            if (bits_left_reg != '0)
            begin
                bits_left_next = bits_left_reg - 1'b1;
            end
        end

        // Deliver the result; a zero modulus yields zero.
        if (uw.emit && out_free)
        begin
            out_valid_next = 1'b1;
            power_next     = (mod_reg == '0) ? 16'd0 : res_ext[15:0];
        end

        // Step sequencing.
        case (uw.jmp)
            JMP_SEQ:
            begin
                if (go)
                begin
                    upc_next = upc_reg + 1'b1;
                end
            end
            JMP_WAIT_IN:
            begin
                if (in_acc)
                begin
                    upc_next = upc_reg + 1'b1;
                end
            end
            JMP_BIT_CLR:
            begin
                if (go)
                begin
                    upc_next = exp_reg[EXP_WIDTH-1] ? (upc_reg + 1'b1) : uw.target;
                end
            end
            JMP_MORE:
            begin
                upc_next = (bits_left_reg != '0) ? uw.target : (upc_reg + 1'b1);
            end
            JMP_WAIT_OUT:
            begin
                if (out_free)
                begin
                    upc_next = uw.target;
                end
            end
            default:
            begin
                upc_next = UPC_IDLE;
            end
        endcase
    end

    // Control state and the configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= UPC_IDLE;
            out_valid_reg <= 1'b0;
            mod_reg       <= RST_EXT[MOD_WIDTH-1:0];
        end
        else
        begin
            upc_reg       <= upc_next;
            out_valid_reg <= out_valid_next;
            mod_reg       <= mod_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        exp_reg       <= exp_next;
        bits_left_reg <= bits_left_next;
        base_reg      <= base_next;
        acc_reg       <= acc_next;
        m_reg         <= m_next;
        power_reg     <= power_next;
    end

    // Checks on the sequencer and the reduction unit.
    `MX_ASSERT_NOW(a_accept_idle, clk, rst_n, in_acc, !mm_stat.busy && !mm_stat.done,
        "request accepted while the multiply-reduce unit is active")
    `MX_ASSERT_NOW(a_reduced, clk, rst_n, mm_stat.done && (mod_reg != '0), mm_result < mod_reg,
        "reduced value not below the modulus")
    `MX_ASSERT_NOW(a_done_in_step, clk, rst_n, mm_stat.done, uw.reduce,
        "reduction finished outside a reducing step")
    `MX_ASSERT_NEXT(a_emit_loads, clk, rst_n, uw.emit && out_free, out_valid_reg,
        "emit step did not load the output register")

endmodule
